// ===== hdl/kmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// kmsa_pkg: shared types and constants for the keyed map slot allocator
// Sizes, opcodes, status codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package kmsa_pkg;

    localparam int MAP_SLOTS   = 64;
    localparam int NUM_MAPS    = 4;
    localparam int KEY_BITS    = 64;
    localparam int SLOT_W      = $clog2(MAP_SLOTS);
    localparam int MAP_W       = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
    localparam int NSLOTS      = NUM_MAPS * MAP_SLOTS;
    localparam int IDX_W       = $clog2(NSLOTS);
    localparam int CNT_W       = SLOT_W + 1;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] REG_REGION_BASE = 2'd0;
    localparam logic [1:0] REG_VALUE_BYTES = 2'd1;
    localparam logic [1:0] REG_ENTRY_LIMIT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  map_select;
        logic [63:0] key_word;
        logic [63:0] value_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_present;
        logic [5:0]  slot_out;
        logic [16:0] byte_offset;
        logic [63:0] value_out;
    } rsp_t;

    typedef struct packed {
        logic [15:0] region_base;
        logic [3:0]  value_bytes;
        logic [6:0]  entry_limit;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic scan;      // walk key store one slot per cycle
        logic decide;    // evaluate outcome, issue writes
        logic finish;    // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

// ===== hdl/kmsa_if.sv =====
// ----------------------------------------------------------------------------
// kmsa_if: valid/ready channel carrying one payload beat
// Generic handshake interface with source and sink views.
// ----------------------------------------------------------------------------
interface kmsa_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/kmsa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kmsa_cfg_if: configuration write channel
// Carries a register index and write data under valid/ready.
// ----------------------------------------------------------------------------
interface kmsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/kmsa_ram.sv =====
// ----------------------------------------------------------------------------
// kmsa_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kmsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/kmsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmsa_ctrl: request sequencer
// Accepts a request, runs the key scan, decides, and presents the result.
// ----------------------------------------------------------------------------
module kmsa_ctrl
    import kmsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd,
    input  sts_t sts
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept while idle; a held result waits in the output register meanwhile
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_finish_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready)) else $error("result overwritten");
    a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg) else $error("result lost");
endmodule

// ===== hdl/kmsa_dp.sv =====
// ----------------------------------------------------------------------------
// kmsa_dp: map storage and slot allocation datapath
// Key/value/free-slot memories, per-map counters, offset arithmetic.
// ----------------------------------------------------------------------------
module kmsa_dp
    import kmsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);
    req_t                req_reg;
    logic [SLOT_W-1:0]   scan_reg;
    logic [SLOT_W-1:0]   scan_prev_reg;
    logic                scan_vld_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;
    logic [NSLOTS-1:0]   valid_reg;
    logic [SLOT_W-1:0]   head_reg  [NUM_MAPS];
    logic [CNT_W-1:0]    count_reg [NUM_MAPS];
    logic [CNT_W-1:0]    fresh_reg [NUM_MAPS];
    rsp_t                rsp_reg, rsp_next;
    rsp_t                out_reg, out_next;
    logic [16:0]         pos_reg;
    logic                map_ok;
    logic [MAP_W-1:0]    m;
    logic [63:0]         key_m;
    logic [63:0]         key_rd, val_rd;
    logic [SLOT_W-1:0]   fifo_rd;
    logic [IDX_W-1:0]    key_raddr, val_raddr, fifo_raddr;
    logic                key_we, val_we, fifo_we;
    logic [IDX_W-1:0]    wr_idx, fifo_waddr;
    logic [SLOT_W-1:0]   slot_sel, tail;
    logic [3:0]          eff_bytes;
    logic [CNT_W-1:0]    eff_limit;
    logic [63:0]         vmask;
    logic                ok;
    logic                alloc_fifo, alloc_fresh;
    logic [7:0]          map_limit;

    assign m      = req_reg.map_select[MAP_W-1:0];
    assign map_ok = {30'd0, req_reg.map_select} < NUM_MAPS;
    assign key_m  = (KEY_BITS >= 64) ? req_reg.key_word
                  : (req_reg.key_word & ((64'd1 << KEY_BITS) - 64'd1));
    assign eff_bytes = (cfg.value_bytes > 4'd8) ? 4'd8 : cfg.value_bytes;
    assign eff_limit = ({25'd0, cfg.entry_limit} > MAP_SLOTS) ? CNT_W'(MAP_SLOTS)
                     : CNT_W'(cfg.entry_limit);
    assign vmask = (eff_bytes == 4'd8) ? '1 : ((64'd1 << {eff_bytes, 3'b000}) - 64'd1);

    // outcome of an update miss
    assign alloc_fifo  = !hit_reg && (count_reg[m] != '0);
    assign alloc_fresh = !hit_reg && (count_reg[m] == '0) && (fresh_reg[m] < eff_limit);
    assign ok          = hit_reg || alloc_fifo || alloc_fresh;
    assign slot_sel    = hit_reg ? hit_slot_reg : alloc_fifo ? fifo_rd
                       : fresh_reg[m][SLOT_W-1:0];
    assign wr_idx      = IDX_W'({m, slot_sel});
    assign tail        = head_reg[m] + count_reg[m][SLOT_W-1:0];
    assign fifo_waddr  = IDX_W'({m, tail});

    assign key_raddr  = IDX_W'({m, scan_reg});
    assign val_raddr  = IDX_W'({m, hit_slot_reg});
    assign fifo_raddr = IDX_W'({m, head_reg[m]});
    assign key_we  = cmd.decide && map_ok && req_reg.opcode == OP_UPDATE && ok;
    assign val_we  = key_we;
    assign fifo_we = cmd.decide && map_ok && req_reg.opcode == OP_DELETE && hit_reg
                   && count_reg[m] < CNT_W'(MAP_SLOTS);

    kmsa_ram #(.WIDTH(64), .DEPTH(NSLOTS)) u_key (.clk(clk), .we(key_we), .waddr(wr_idx),
        .wdata(key_m), .raddr(key_raddr), .rdata(key_rd));
    kmsa_ram #(.WIDTH(64), .DEPTH(NSLOTS)) u_val (.clk(clk), .we(val_we), .waddr(wr_idx),
        .wdata(req_reg.value_word & vmask), .raddr(val_raddr), .rdata(val_rd));
    kmsa_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOTS)) u_fifo (.clk(clk), .we(fifo_we),
        .waddr(fifo_waddr), .wdata(hit_slot_reg), .raddr(fifo_raddr), .rdata(fifo_rd));

    assign sts.scan_done = scan_vld_reg && scan_prev_reg == SLOT_W'(MAP_SLOTS - 1);
    assign rsp           = out_reg;
    assign map_limit     = 8'(m) * 8'(eff_limit);

    // scan, match and commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            scan_reg      <= '0;
            scan_prev_reg <= '0;
            scan_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hit_slot_reg  <= '0;
            for (int i = 0; i < NUM_MAPS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                fresh_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                scan_reg     <= '0;
                scan_vld_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
            if (cmd.scan)
            begin
                scan_reg      <= scan_reg + 1'b1;
                scan_prev_reg <= scan_reg;
                scan_vld_reg  <= 1'b1;
                if (scan_vld_reg && !hit_reg && valid_reg[IDX_W'({m, scan_prev_reg})]
                    && key_rd == key_m)
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= scan_prev_reg;
                end
            end
            if (cmd.decide && map_ok)
            begin
                unique case (req_reg.opcode)
                    OP_UPDATE:
                    begin
                        if (ok)
                        begin
                            valid_reg[wr_idx] <= 1'b1;
                        end
                        if (alloc_fifo)
                        begin
                            head_reg[m]  <= head_reg[m] + 1'b1;
                            count_reg[m] <= count_reg[m] - 1'b1;
                        end
                        if (alloc_fresh)
                        begin
                            fresh_reg[m] <= fresh_reg[m] + 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            valid_reg[IDX_W'({m, hit_slot_reg})] <= 1'b0;
                            if (fifo_we)
                            begin
                                count_reg[m] <= count_reg[m] + 1'b1;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int s = 0; s < MAP_SLOTS; s++)
                        begin
                            valid_reg[IDX_W'({m, SLOT_W'(s)})] <= 1'b0;
                        end
                        head_reg[m]  <= '0;
                        count_reg[m] <= '0;
                        fresh_reg[m] <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // build the decided result
    always_comb
    begin
        rsp_next = '0;
        if (!map_ok)
        begin
            rsp_next.status = (req_reg.opcode == OP_UPDATE) ? ST_FULL
                            : (req_reg.opcode == OP_CLEAR) ? ST_DONE : ST_NOTFOUND;
        end
        else if (req_reg.opcode == OP_UPDATE)
        begin
            rsp_next.status      = ok ? ST_DONE : ST_FULL;
            rsp_next.was_present = hit_reg;
            rsp_next.slot_out    = ok ? 6'(slot_sel) : '0;
        end
        else if (req_reg.opcode != OP_CLEAR)
        begin
            rsp_next.status      = hit_reg ? ST_DONE : ST_NOTFOUND;
            rsp_next.was_present = hit_reg;
            rsp_next.slot_out    = hit_reg ? 6'(hit_slot_reg) : '0;
            if (req_reg.opcode == OP_LOOKUP && hit_reg)
            begin
                rsp_next.value_out = val_rd & vmask;
            end
        end
    end

    // add the byte offset on the way to the output register
    always_comb
    begin
        out_next = rsp_reg;
        if (rsp_reg.status == ST_DONE && map_ok && req_reg.opcode != OP_CLEAR)
        begin
            out_next.byte_offset = 17'(cfg.region_base) + 17'(pos_reg * 17'(eff_bytes));
        end
    end

    // payload: request capture, result build and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.decide)
        begin
            rsp_reg <= rsp_next;
            pos_reg <= 17'(map_limit) + 17'(slot_sel);
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> count_reg[m] <= CNT_W'(MAP_SLOTS)) else $error("fifo overflow");
    a_fresh_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> fresh_reg[m] <= CNT_W'(MAP_SLOTS)) else $error("fresh overflow");
    a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(key_we && fifo_we)) else $error("update and delete at once");
endmodule

// ===== hdl/keyed_map_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// keyed_map_slot_allocator_top: multi-map key/value store with slot reuse
// Top level joining sequencer, datapath and configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   req  : sink channel, one beat per request (opcode, map, key, value).
//   rsp  : source channel, one beat per request (status, slot, offset, value).
//   cfg  : write channel, index 0 region_base, 1 value_bytes, 2 entry_limit;
//          always ready, write only while idle.
// Operation: each request walks the map's key store one slot per cycle through
//   a registered-read RAM, then waits, decides and loads the output register;
//   one request is worked at a time and the next is accepted from the cycle
//   the result shows.
// Reset: all maps empty, registers at 512 / 8 / 64. No clearing pass; key
//   valid bits are flip-flops cleared at once.
// Stall: a result held by the receiver sits in the output register; a new
//   request may be accepted and worked, and waits only to present its result.
// ----------------------------------------------------------------------------
module keyed_map_slot_allocator_top
    import kmsa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    kmsa_if.sink    req,
    kmsa_if.source  rsp,
    kmsa_cfg_if.sink cfg
);
    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_base <= 16'd512;
            cfg_reg.value_bytes <= 4'd8;
            cfg_reg.entry_limit <= 7'd64;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_REGION_BASE: cfg_reg.region_base <= cfg.data;
                REG_VALUE_BYTES: cfg_reg.value_bytes <= cfg.data[3:0];
                REG_ENTRY_LIMIT: cfg_reg.entry_limit <= cfg.data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    kmsa_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(cmd), .sts(sts));

    kmsa_dp u_dp (.clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .req(req.data), .cmd(cmd),
        .sts(sts), .rsp(rsp.data));
endmodule
